// ===== design/rectangle_fill_outline_raster_top_defines.svh =====
// Assertion macros used by the rectangle rasterizer back end.
`ifndef RECTANGLE_FILL_OUTLINE_RASTER_TOP_DEFINES_SVH
`define RECTANGLE_FILL_OUTLINE_RASTER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define RFOR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define RFOR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rfor_pkg.sv =====
// Types and constants of the rectangle rasterizer.
`timescale 1ns / 1ps
package rfor_pkg;

    // item kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DRAW  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ERR   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // commands from the front to the back
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_DRAW  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BG     = 2'd2;

    localparam logic [7:0] CODE_FILL    = 8'h52;  // 'R'
    localparam logic [7:0] CODE_OUTLINE = 8'h72;  // 'r'

    localparam int CFG_W    = 10;
    localparam int BYTE_W   = 8;
    localparam int RDPOS_W  = 9;
    localparam int CMP_W    = 16;                 // width for size compares
    localparam logic [CFG_W-1:0]  SIDE_RST = 10'd1;
    localparam logic [BYTE_W-1:0] BG_RST   = 8'd32;

    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         status;
        logic               fill;
        logic [BYTE_W-1:0]  paint;
        logic [RDPOS_W-1:0] rd_col;
        logic [RDPOS_W-1:0] rd_row;
    } t_cmd_ctl;

    typedef struct packed {
        logic [1:0]        status;
        logic [BYTE_W-1:0] cell_byte;
    } t_res;

    localparam int CTL_W = $bits(t_cmd_ctl);
    localparam int RES_W = $bits(t_res);

endpackage

// ===== design/rfor_fifo.sv =====
// Two-entry queue used between front and back and on the result side.
`timescale 1ns / 1ps
module rfor_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== design/rfor_front.sv =====
// Front end: config registers, error flag, item checks and edge precompute.
`timescale 1ns / 1ps
module rfor_front #(
    parameter int MAX_SIDE   = 512,
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8,
    localparam int XB   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
    localparam int SW_A = COORD_BITS + 2,
    localparam int SW_B = XB + FRAC_BITS + 2,
    localparam int SW   = (SW_A > SW_B) ? SW_A : SW_B
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [rfor_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_push,
    input  logic                         i_q_full,
    input  logic [1:0]                   i_kind,
    input  logic [7:0]                   i_shape_code,
    input  logic signed [COORD_BITS-1:0] i_rect_left,
    input  logic signed [COORD_BITS-1:0] i_rect_top,
    input  logic signed [COORD_BITS-1:0] i_rect_width,
    input  logic signed [COORD_BITS-1:0] i_rect_height,
    input  logic [7:0]                   i_paint_byte,
    input  logic [8:0]                   i_read_column,
    input  logic [8:0]                   i_read_row,
    output logic                         o_q_push,
    output rfor_pkg::t_cmd_ctl           o_ctl,
    output logic [8*SW-1:0]              o_bnd,
    output logic [XB:0]                  o_w_use,
    output logic [XB:0]                  o_h_use,
    output logic [7:0]                   o_bg
);
    import rfor_pkg::*;

    localparam logic signed [SW-1:0] ONE = {{(SW-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic [CFG_W-1:0]  r_cfg_w, r_cfg_h;
    logic [BYTE_W-1:0] r_bg;
    logic              r_err, n_err;
    logic              accept, bad_draw;
    logic signed [SW-1:0] l, l1, r, r1, t, t1, b, b1;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_push && !i_q_full;
    assign o_q_push    = accept;
    assign o_bg        = r_bg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= SIDE_RST;
            r_cfg_h <= SIDE_RST;
            r_bg    <= BG_RST;
            r_err   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                    CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                    CFG_BG:     r_bg    <= i_cfg_data[BYTE_W-1:0];
                    default:    ;
                endcase
            end
            r_err <= n_err;
        end
    end

    // 0 counts as 1, anything above MAX_SIDE as MAX_SIDE
    always_comb begin
        if (r_cfg_w == '0) begin
            o_w_use = (XB+1)'(1);
        end else if (CMP_W'(r_cfg_w) > CMP_W'(MAX_SIDE)) begin
            o_w_use = (XB+1)'(MAX_SIDE);
        end else begin
            o_w_use = (XB+1)'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            o_h_use = (XB+1)'(1);
        end else if (CMP_W'(r_cfg_h) > CMP_W'(MAX_SIDE)) begin
            o_h_use = (XB+1)'(MAX_SIDE);
        end else begin
            o_h_use = (XB+1)'(r_cfg_h);
        end
    end

    // closed rectangle edges and the one-unit border limits
    assign l  = SW'(i_rect_left);
    assign t  = SW'(i_rect_top);
    assign r  = l + SW'(i_rect_width);
    assign b  = t + SW'(i_rect_height);
    assign l1 = l + ONE;
    assign t1 = t + ONE;
    assign r1 = r - ONE;
    assign b1 = b - ONE;
    assign o_bnd = {l, l1, r, r1, t, t1, b, b1};

    assign bad_draw = (i_rect_width <= 0) || (i_rect_height <= 0) ||
                      !((i_shape_code == CODE_FILL) || (i_shape_code == CODE_OUTLINE));

    always_comb begin
        o_ctl        = '0;
        o_ctl.op     = OP_NONE;
        o_ctl.status = r_err ? ST_ERR : ST_OK;
        o_ctl.fill   = (i_shape_code == CODE_FILL);
        o_ctl.paint  = i_paint_byte;
        o_ctl.rd_col = i_read_column;
        o_ctl.rd_row = i_read_row;
        n_err        = r_err;
        unique case (i_kind)
            KIND_START: begin
                o_ctl.op     = OP_CLEAR;
                o_ctl.status = ST_OK;
                if (accept) begin
                    n_err = 1'b0;
                end
            end
            KIND_DRAW: begin
                if (!r_err) begin
                    if (bad_draw) begin
                        o_ctl.status = ST_ERR;
                        if (accept) begin
                            n_err = 1'b1;
                        end
                    end else begin
                        o_ctl.op = OP_DRAW;
                    end
                end
            end
            KIND_READ: begin
                if (!r_err) begin
                    if ((CMP_W'(i_read_column) >= CMP_W'(o_w_use)) ||
                        (CMP_W'(i_read_row) >= CMP_W'(o_h_use))) begin
                        o_ctl.status = ST_RANGE;
                    end else begin
                        o_ctl.op = OP_READ;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== design/rfor_back.sv =====
// Back end: canvas memory, clear sweep, draw scan and cell reads.
`timescale 1ns / 1ps
`include "rectangle_fill_outline_raster_top_defines.svh"
module rfor_back #(
    parameter int MAX_SIDE   = 512,
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8,
    localparam int XB   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
    localparam int SW_A = COORD_BITS + 2,
    localparam int SW_B = XB + FRAC_BITS + 2,
    localparam int SW   = (SW_A > SW_B) ? SW_A : SW_B
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_empty,
    input  rfor_pkg::t_cmd_ctl i_cmd_ctl,
    input  logic [8*SW-1:0]    i_cmd_bnd,
    output logic               o_cmd_pop,
    input  logic [XB:0]        i_w_use,
    input  logic [XB:0]        i_h_use,
    input  logic [7:0]         i_bg,
    input  logic               i_res_full,
    output logic               o_res_push,
    output rfor_pkg::t_res     o_res
);
    import rfor_pkg::*;

    localparam int AW    = 2 * XB;
    localparam int DEPTH = 1 << AW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_DRAW  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [BYTE_W-1:0] r_canvas [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    logic [2:0]      r_state, n_state;
    t_cmd_ctl        r_ctl, n_ctl;
    logic [8*SW-1:0] r_bnd, n_bnd;
    logic [XB-1:0]   r_x, n_x, r_y, n_y;
    logic [AW-1:0]   r_clr, n_clr;

    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [BYTE_W-1:0] mem_wd;
    logic [AW-1:0]     rd_addr;
    logic [CMP_W-1:0]  rd_col_w, rd_row_w;

    logic signed [SW-1:0] l, l1, r, r1, t, t1, b, b1, px, py;
    logic in_rect, on_border, paint_cell, x_last, y_last;

    assign {l, l1, r, r1, t, t1, b, b1} = r_bnd;

    // cell (x, y) sits at the point (x, y) in the fixed-point grid
    assign px = $signed(SW'(r_x) << FRAC_BITS);
    assign py = $signed(SW'(r_y) << FRAC_BITS);

    assign in_rect    = (px >= l) && (px <= r) && (py >= t) && (py <= b);
    assign on_border  = (px < l1) || (px > r1) || (py < t1) || (py > b1);
    assign paint_cell = in_rect && (on_border || r_ctl.fill);

    assign x_last = (CMP_W'(r_x) == CMP_W'(i_w_use) - CMP_W'(1));
    assign y_last = (CMP_W'(r_y) == CMP_W'(i_h_use) - CMP_W'(1));

    // in-range reads fit in XB bits
    assign rd_col_w = CMP_W'(r_ctl.rd_col);
    assign rd_row_w = CMP_W'(r_ctl.rd_row);
    assign rd_addr  = {rd_row_w[XB-1:0], rd_col_w[XB-1:0]};

    always_comb begin
        n_state    = r_state;
        n_ctl      = r_ctl;
        n_bnd      = r_bnd;
        n_x        = r_x;
        n_y        = r_y;
        n_clr      = r_clr;
        mem_we     = 1'b0;
        mem_wa     = {r_y, r_x};
        mem_wd     = r_ctl.paint;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_ctl     = i_cmd_ctl;
                    n_bnd     = i_cmd_bnd;
                    n_x       = '0;
                    n_y       = '0;
                    n_clr     = '0;
                    unique case (i_cmd_ctl.op)
                        OP_CLEAR: n_state = S_CLEAR;
                        OP_DRAW:  n_state = S_DRAW;
                        OP_READ:  n_state = S_READ;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = i_bg;
                if (&r_clr) begin
                    n_state = S_DONE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_DRAW: begin
                mem_we = paint_cell;
                if (x_last) begin
                    n_x = '0;
                    if (y_last) begin
                        n_state = S_DONE;
                    end else begin
                        n_y = r_y + XB'(1);
                    end
                end else begin
                    n_x = r_x + XB'(1);
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_res.status    = r_ctl.status;
        o_res.cell_byte = '0;
        if ((r_ctl.op == OP_READ) && (r_ctl.status == ST_OK)) begin
            o_res.cell_byte = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl <= n_ctl;
        r_bnd <= n_bnd;
        r_x   <= n_x;
        r_y   <= n_y;
        r_clr <= n_clr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_canvas[mem_wa] <= mem_wd;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_canvas[rd_addr];
        end
    end

    `RFOR_ASSERT_IMP(a_scan_in_canvas, r_state == S_DRAW, (CMP_W'(r_x) < CMP_W'(i_w_use)) && (CMP_W'(r_y) < CMP_W'(i_h_use)), "draw scan left the canvas")
    `RFOR_ASSERT_NXT(a_clear_ends, (r_state == S_CLEAR) && (&r_clr), r_state == S_DONE, "clear sweep did not finish")
    `RFOR_ASSERT_NXT(a_pop_starts_work, o_cmd_pop, r_state != S_IDLE, "command taken but back end idle")
    `RFOR_ASSERT_IMP(a_draw_is_clean, r_state == S_DRAW, (r_ctl.op == OP_DRAW) && (r_ctl.status == ST_OK), "draw running for a rejected item")

endmodule

// ===== design/rectangle_fill_outline_raster_top.sv =====
// Top level of the rectangle fill and outline rasterizer.
//
//   channel   handshake              payload
//   -------   --------------------   ---------------------------------------------
//   config    i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//   items     push/full              i_kind, i_shape_code, i_rect_*, i_paint_byte,
//                                    i_read_column, i_read_row
//   results   empty/pop              o_status, o_cell_byte
//
// Start: (2*XB)-bit address sweep of the canvas RAM, covering all MAX_SIDE^2 addresses at
// a power-of-two MAX_SIDE (262144 at 512). Draw: a scan over the width*height cells in use,
// one cell per cycle through the single RAM write port. Read: a registered RAM read.
// Reset is synchronous; the canvas holds no defined value until a start.
// A two-entry command queue lets the front keep taking items while the back is busy,
// and a two-entry result queue holds results while pop is low.
`timescale 1ns / 1ps
module rectangle_fill_outline_raster_top #(
    parameter int MAX_SIDE   = 512,
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [rfor_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   i_kind,
    input  logic [7:0]                   i_shape_code,
    input  logic signed [COORD_BITS-1:0] i_rect_left,
    input  logic signed [COORD_BITS-1:0] i_rect_top,
    input  logic signed [COORD_BITS-1:0] i_rect_width,
    input  logic signed [COORD_BITS-1:0] i_rect_height,
    input  logic [7:0]                   i_paint_byte,
    input  logic [8:0]                   i_read_column,
    input  logic [8:0]                   i_read_row,
    output logic                         empty,
    input  logic                         pop,
    output logic [1:0]                   o_status,
    output logic [7:0]                   o_cell_byte
);
    import rfor_pkg::*;

    localparam int XB    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SW_A  = COORD_BITS + 2;
    localparam int SW_B  = XB + FRAC_BITS + 2;
    localparam int SW    = (SW_A > SW_B) ? SW_A : SW_B;
    localparam int CMD_W = CTL_W + 8 * SW;

    logic             q_push, q_full, q_empty, q_pop;
    t_cmd_ctl         f_ctl, b_ctl;
    logic [8*SW-1:0]  f_bnd, b_bnd;
    logic [CMD_W-1:0] q_out;
    logic [XB:0]      w_use, h_use;
    logic [7:0]       bg;
    logic             res_push, res_full;
    t_res             res_in, res_out;

    rfor_front #(
        .MAX_SIDE   (MAX_SIDE),
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_q_full      (q_full),
        .i_kind        (i_kind),
        .i_shape_code  (i_shape_code),
        .i_rect_left   (i_rect_left),
        .i_rect_top    (i_rect_top),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_paint_byte  (i_paint_byte),
        .i_read_column (i_read_column),
        .i_read_row    (i_read_row),
        .o_q_push      (q_push),
        .o_ctl         (f_ctl),
        .o_bnd         (f_bnd),
        .o_w_use       (w_use),
        .o_h_use       (h_use),
        .o_bg          (bg)
    );

    rfor_fifo #(
        .W (CMD_W)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_ctl, f_bnd}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    assign full  = q_full;
    assign b_ctl = t_cmd_ctl'(q_out[CMD_W-1 -: CTL_W]);
    assign b_bnd = q_out[8*SW-1:0];

    rfor_back #(
        .MAX_SIDE   (MAX_SIDE),
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (q_empty),
        .i_cmd_ctl   (b_ctl),
        .i_cmd_bnd   (b_bnd),
        .o_cmd_pop   (q_pop),
        .i_w_use     (w_use),
        .i_h_use     (h_use),
        .i_bg        (bg),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    rfor_fifo #(
        .W (RES_W)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_status    = res_out.status;
    assign o_cell_byte = res_out.cell_byte;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the rectangle fill and outline rasterizer.
`timescale 1ns / 1ps

import rfor_pkg::*;

localparam int SIDE_MAX     = 512;
localparam int COORD_BITS   = 24;
localparam int FRAC_ONE     = 256;
localparam int CANVAS_CELLS = SIDE_MAX * SIDE_MAX;

localparam logic [1:0] KIND_NOP   = 2'd3;
localparam logic [1:0] CFG_UNUSED = 2'd3;

localparam int LONG_STALL   = 2000;
localparam int DRAIN_CYCLES = 64;
localparam longint CYCLE_LIMIT = 8_000_000;

typedef enum {BAD_WIDTH, BAD_HEIGHT, BAD_SHAPE} bad_draw_e;

typedef struct {
    logic [1:0]                   kind;
    logic [7:0]                   shape_code;
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] top;
    logic signed [COORD_BITS-1:0] wid;
    logic signed [COORD_BITS-1:0] hgt;
    logic [BYTE_W-1:0]            paint;
    logic [RDPOS_W-1:0]           col;
    logic [RDPOS_W-1:0]           row;
} raster_item_t;

class raster_scoreboard;
    logic [BYTE_W-1:0] canvas [CANVAS_CELLS];
    bit                error_flag;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [BYTE_W-1:0] bg_reg;
    t_res              pending_results[$];
    int                fail_count;

    function new();
        width_reg  = SIDE_RST;
        height_reg = SIDE_RST;
        bg_reg     = BG_RST;
        error_flag = 1'b0;
        fail_count = 0;
    endfunction

    function int clamp_side(logic [CFG_W-1:0] r);
        if (r == 0)
            return 1;
        if (r > SIDE_MAX)
            return SIDE_MAX;
        return int'(r);
    endfunction

    function int cols_in_use();
        return clamp_side(width_reg);
    endfunction

    function int rows_in_use();
        return clamp_side(height_reg);
    endfunction

    function void write_reg(logic [1:0] index, logic [CFG_W-1:0] data);
        case (index)
            CFG_WIDTH:  width_reg  = data;
            CFG_HEIGHT: height_reg = data;
            CFG_BG:     bg_reg     = data[BYTE_W-1:0];
            default:    ;
        endcase
    endfunction

    // every cell is tested at its integer point against the closed rectangle
    function void paint_rect(raster_item_t it);
        longint one, l, t, r, b, px, py;
        int     w, h;
        bit     filled, in_rect, border;
        one    = FRAC_ONE;
        l      = it.left;
        t      = it.top;
        r      = l + it.wid;
        b      = t + it.hgt;
        w      = cols_in_use();
        h      = rows_in_use();
        filled = (it.shape_code == CODE_FILL);
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                px      = longint'(x) * one;
                py      = longint'(y) * one;
                in_rect = !(px < l || px > r || py < t || py > b);
                border  = (px - l < one) || (r - px < one) || (py - t < one) || (b - py < one);
                if (in_rect && (border || filled))
                    canvas[y * SIDE_MAX + x] = it.paint;
            end
        end
    endfunction

    function t_res rasterize_item(raster_item_t it);
        t_res res;
        res.status    = ST_OK;
        res.cell_byte = '0;
        case (it.kind)
            KIND_START: begin
                foreach (canvas[i])
                    canvas[i] = bg_reg;
                error_flag = 1'b0;
            end
            KIND_DRAW: begin
                if (error_flag) begin
                    res.status = ST_ERR;
                end else if (it.wid <= 0 || it.hgt <= 0 ||
                             !(it.shape_code == CODE_FILL || it.shape_code == CODE_OUTLINE)) begin
                    error_flag = 1'b1;
                    res.status = ST_ERR;
                end else begin
                    paint_rect(it);
                end
            end
            KIND_READ: begin
                if (error_flag)
                    res.status = ST_ERR;
                else if (it.col >= cols_in_use() || it.row >= rows_in_use())
                    res.status = ST_RANGE;
                else
                    res.cell_byte = canvas[int'(it.row) * SIDE_MAX + int'(it.col)];
            end
            default: begin
                if (error_flag)
                    res.status = ST_ERR;
            end
        endcase
        return res;
    endfunction

    function void note_item(raster_item_t it);
        pending_results.push_back(rasterize_item(it));
    endfunction

    function void check_result(logic [1:0] status, logic [BYTE_W-1:0] cell_byte);
        t_res exp;
        if (pending_results.size() == 0) begin
            $error("result with no item outstanding: status %0d cell_byte %0d", status,
                   cell_byte);
            fail_count++;
            return;
        end
        exp = pending_results.pop_front();
        if (status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, status);
            fail_count++;
        end
        if (cell_byte !== exp.cell_byte) begin
            $error("cell_byte: expected %0d, got %0d", exp.cell_byte, cell_byte);
            fail_count++;
        end
    endfunction

    function int pending();
        return pending_results.size();
    endfunction
endclass

module tb_top;
    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [1:0]                   i_cfg_index;
    logic [CFG_W-1:0]             i_cfg_data;
    logic                         push;
    logic                         full;
    logic [1:0]                   i_kind;
    logic [7:0]                   i_shape_code;
    logic signed [COORD_BITS-1:0] i_rect_left;
    logic signed [COORD_BITS-1:0] i_rect_top;
    logic signed [COORD_BITS-1:0] i_rect_width;
    logic signed [COORD_BITS-1:0] i_rect_height;
    logic [7:0]                   i_paint_byte;
    logic [8:0]                   i_read_column;
    logic [8:0]                   i_read_row;
    logic                         empty;
    logic                         pop;
    logic [1:0]                   o_status;
    logic [7:0]                   o_cell_byte;

    raster_scoreboard sb;
    bit               rst_done;
    bit               stall_request;
    bit               sender_no_gaps;
    int               results_taken;
    longint           cycle_count;

    rectangle_fill_outline_raster_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_kind        (i_kind),
        .i_shape_code  (i_shape_code),
        .i_rect_left   (i_rect_left),
        .i_rect_top    (i_rect_top),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_paint_byte  (i_paint_byte),
        .i_read_column (i_read_column),
        .i_read_row    (i_read_row),
        .empty         (empty),
        .pop           (pop),
        .o_status      (o_status),
        .o_cell_byte   (o_cell_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic raster_item_t random_fields();
        raster_item_t it;
        it.kind       = 2'($urandom);
        it.shape_code = 8'($urandom);
        it.left       = COORD_BITS'($urandom);
        it.top        = COORD_BITS'($urandom);
        it.wid        = COORD_BITS'($urandom);
        it.hgt        = COORD_BITS'($urandom);
        it.paint      = 8'($urandom);
        it.col        = RDPOS_W'($urandom);
        it.row        = RDPOS_W'($urandom);
        return it;
    endfunction

    function automatic raster_item_t kind_item(logic [1:0] kind);
        raster_item_t it;
        it      = random_fields();
        it.kind = kind;
        return it;
    endfunction

    function automatic raster_item_t read_item(int c, int r);
        raster_item_t it;
        it      = kind_item(KIND_READ);
        it.col  = RDPOS_W'(c);
        it.row  = RDPOS_W'(r);
        return it;
    endfunction

    function automatic raster_item_t draw_item(logic [7:0] code, int l, int t, int wd, int ht,
                                               logic [7:0] paint);
        raster_item_t it;
        it            = kind_item(KIND_DRAW);
        it.shape_code = code;
        it.left       = COORD_BITS'(l);
        it.top        = COORD_BITS'(t);
        it.wid        = COORD_BITS'(wd);
        it.hgt        = COORD_BITS'(ht);
        it.paint      = paint;
        return it;
    endfunction

    // mix of sub-unit, whole-unit and arbitrary fractional sizes
    function automatic int random_size(int side);
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, FRAC_ONE - 1);
            1:       return FRAC_ONE * $urandom_range(1, side + 1);
            default: return $urandom_range(1, (side + 2) * FRAC_ONE);
        endcase
    endfunction

    function automatic logic [7:0] good_shape();
        return $urandom_range(0, 1) ? CODE_FILL : CODE_OUTLINE;
    endfunction

    task automatic wait_results_drained();
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [CFG_W-1:0] data);
        push <= 1'b0;
        wait_results_drained();
        repeat (16) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_reg(index, data);
    endtask

    task automatic offer_item(raster_item_t it);
        int gap;
        gap = sender_no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_kind        <= it.kind;
        i_shape_code  <= it.shape_code;
        i_rect_left   <= it.left;
        i_rect_top    <= it.top;
        i_rect_width  <= it.wid;
        i_rect_height <= it.hgt;
        i_paint_byte  <= it.paint;
        i_read_column <= it.col;
        i_read_row    <= it.row;
        do @(posedge i_clk); while (full);
        sb.note_item(it);
    endtask

    // one start, then mostly well-formed draws and reads; one bad draw near the end
    task automatic run_random_phase(int n_items, int err_at, bad_draw_e flavor,
                                    int pause_at, int stall_at);
        raster_item_t it;
        int           w, h, pick;
        offer_item(kind_item(KIND_START));
        for (int i = 1; i <= n_items; i++) begin
            if (i == pause_at) begin
                push <= 1'b0;
                @(posedge i_clk);
                wait_results_drained();
            end
            if (i == stall_at)
                stall_request = 1'b1;
            w    = sb.cols_in_use();
            h    = sb.rows_in_use();
            pick = $urandom_range(0, 99);
            if (i == err_at) begin
                it = draw_item(good_shape(), int'($urandom_range(0, w * FRAC_ONE)),
                               int'($urandom_range(0, h * FRAC_ONE)), random_size(w),
                               random_size(h), 8'($urandom));
                case (flavor)
                    BAD_WIDTH:  it.wid = COORD_BITS'(-int'($urandom_range(0, 8388608)));
                    BAD_HEIGHT: it.hgt = COORD_BITS'(-int'($urandom_range(0, 8388608)));
                    default: begin
                        do it.shape_code = 8'($urandom);
                        while (it.shape_code == CODE_FILL || it.shape_code == CODE_OUTLINE);
                    end
                endcase
            end else if (pick < 45) begin
                it = draw_item(good_shape(),
                               int'($urandom_range(0, (w + 4) * FRAC_ONE)) - 3 * FRAC_ONE,
                               int'($urandom_range(0, (h + 4) * FRAC_ONE)) - 3 * FRAC_ONE,
                               random_size(w), random_size(h), 8'($urandom));
            end else if (pick < 85) begin
                if ($urandom_range(0, 9) == 0)
                    it = kind_item(KIND_READ);
                else
                    it = read_item($urandom_range(0, (w > 511) ? 511 : w),
                                   $urandom_range(0, (h > 511) ? 511 : h));
            end else if (pick < 92) begin
                // corners anywhere in the coordinate range, sizes positive
                it            = kind_item(KIND_DRAW);
                it.shape_code = good_shape();
                it.wid        = COORD_BITS'($urandom_range(1, 8388607));
                it.hgt        = COORD_BITS'($urandom_range(1, 8388607));
            end else begin
                it = kind_item(KIND_NOP);
            end
            offer_item(it);
        end
    endtask

    // result side: random gaps, bursts without gaps, and one long hold-off on request
    initial begin
        int gap;
        bit burst;
        pop <= 1'b0;
        wait (rst_done);
        @(posedge i_clk);
        forever begin
            burst = ((results_taken / 25) % 2) == 1;
            gap   = burst ? 0 : $urandom_range(0, 17);
            if (stall_request) begin
                stall_request = 1'b0;
                gap += LONG_STALL;
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            sb.check_result(o_status, o_cell_byte);
            results_taken++;
        end
    end

    initial begin
        sb             = new();
        rst_done       = 1'b0;
        stall_request  = 1'b0;
        sender_no_gaps = 1'b0;
        results_taken  = 0;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        push          <= 1'b0;
        i_kind        <= '0;
        i_shape_code  <= '0;
        i_rect_left   <= '0;
        i_rect_top    <= '0;
        i_rect_width  <= '0;
        i_rect_height <= '0;
        i_paint_byte  <= '0;
        i_read_column <= '0;
        i_read_row    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1'b1;

        // reset sizes: a single cell
        offer_item(kind_item(KIND_NOP));
        offer_item(kind_item(KIND_START));
        offer_item(read_item(0, 0));
        offer_item(read_item(1, 0));
        offer_item(read_item(0, 1));
        offer_item(read_item(511, 511));
        offer_item(draw_item(CODE_FILL, 0, 0, FRAC_ONE, FRAC_ONE, 8'hA5));
        offer_item(read_item(0, 0));

        // full canvas: width taken from a value past the top of the range, height at the top
        write_reg(CFG_WIDTH, 10'd1023);
        write_reg(CFG_HEIGHT, 10'd512);
        write_reg(CFG_BG, 10'd0);
        offer_item(draw_item(CODE_OUTLINE, 0, 0, 511 * FRAC_ONE, 511 * FRAC_ONE, 8'h5A));
        offer_item(read_item(0, 0));
        offer_item(read_item(511, 511));
        offer_item(read_item(511, 0));
        offer_item(read_item(5, 5));
        offer_item(read_item(0, 300));
        offer_item(read_item(300, 1));

        // small canvas: extreme coordinates, fractional outline, then the sticky error
        write_reg(CFG_WIDTH, 10'd7);
        write_reg(CFG_HEIGHT, 10'd5);
        write_reg(CFG_BG, 10'd255);
        offer_item(draw_item(CODE_FILL, -8388608, -8388608, 8388607, 8388607, 8'h00));
        offer_item(draw_item(CODE_FILL, 8388607, 8388607, 8388607, 8388607, 8'hFF));
        offer_item(draw_item(CODE_OUTLINE, -128, -128, 6 * FRAC_ONE + 64, 4 * FRAC_ONE, 8'h11));
        offer_item(read_item(5, 3));
        offer_item(read_item(2, 2));
        offer_item(read_item(6, 4));
        offer_item(draw_item(CODE_FILL, 0, 0, 0, FRAC_ONE, 8'h22));
        offer_item(draw_item(CODE_FILL, 0, 0, FRAC_ONE, FRAC_ONE, 8'h33));
        offer_item(read_item(0, 0));
        offer_item(kind_item(KIND_NOP));

        write_reg(CFG_WIDTH, 10'($urandom_range(1, 24)));
        write_reg(CFG_HEIGHT, 10'($urandom_range(1, 24)));
        write_reg(CFG_BG, 10'($urandom));
        run_random_phase(26, 22, BAD_WIDTH, 12, 0);

        // wide and flat canvas, sender without gaps while results are held off
        write_reg(CFG_WIDTH, 10'd1023);
        write_reg(CFG_HEIGHT, 10'($urandom_range(1, 3)));
        write_reg(CFG_BG, 10'd255);
        sender_no_gaps = 1'b1;
        run_random_phase(26, 23, BAD_HEIGHT, 0, 8);
        sender_no_gaps = 1'b0;

        // one column, tallest height; zero size register used as one
        write_reg(CFG_UNUSED, 10'h2AA);
        write_reg(CFG_WIDTH, 10'd0);
        write_reg(CFG_HEIGHT, 10'd1023);
        write_reg(CFG_BG, 10'd0);
        run_random_phase(26, 25, BAD_SHAPE, 0, 0);

        push <= 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
